/* rtl/core/lpps_pkg.sv */
// Shared types, constants and the step table of the LED pulse pattern sequencer.
package lpps_pkg;

  // Default pattern length (steps) and fixed field widths
  localparam int SeqLengthDefault = 22;
  localparam int CountW           = 8;
  localparam int WaitW            = 12;
  localparam int PosW             = 5;
  localparam int CfgIndexW        = 3;
  localparam int CfgDataW         = 12;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_SLOW_EDGE = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_SLOW_ON   = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_SLOW_OFF  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_FAST_EDGE = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_FAST_ON   = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_FAST_OFF  = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_GAP       = 3'd6;

  // Register reset values
  localparam logic [CountW-1:0] SLOW_EDGE_RST = 8'd9;
  localparam logic [CountW-1:0] SLOW_ON_RST   = 8'd14;
  localparam logic [CountW-1:0] SLOW_OFF_RST  = 8'd19;
  localparam logic [CountW-1:0] FAST_EDGE_RST = 8'd1;
  localparam logic [CountW-1:0] FAST_ON_RST   = 8'd2;
  localparam logic [CountW-1:0] FAST_OFF_RST  = 8'd2;
  localparam logic [WaitW-1:0]  GAP_RST       = 12'd2000;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Brightness codes with a meaning
  localparam logic [7:0] BR_LOW  = 8'd0;
  localparam logic [7:0] BR_HIGH = 8'd1;
  localparam logic [7:0] BR_SLOW = 8'd4;
  localparam logic [7:0] BR_FAST = 8'd5;

  // Pin actions
  localparam logic [1:0] ACT_TOGGLE = 2'd0;
  localparam logic [1:0] ACT_LOW    = 2'd1;
  localparam logic [1:0] ACT_HIGH   = 2'd2;

  // Source of a step's action count
  localparam logic [1:0] CNT_FIXED = 2'd0;
  localparam logic [1:0] CNT_EDGE  = 2'd1;
  localparam logic [1:0] CNT_ON    = 2'd2;
  localparam logic [1:0] CNT_OFF   = 2'd3;

  // Delay code that selects the programmable reset gap
  localparam logic [2:0] DLY_GAP = 3'd0;

  typedef struct packed {
    logic [1:0] src;
    logic [2:0] count;
    logic [2:0] delay;
    logic [1:0] act;
  } step_t;

  // Step table; slots past the end keep the pin high
  function automatic step_t step_lookup(input logic [4:0] idx);
    step_t s;
    case (idx) inside
      5'd0, 5'd4:        s = '{CNT_FIXED, 3'd4, 3'd1, ACT_TOGGLE};
      5'd1, 5'd5:        s = '{CNT_FIXED, 3'd1, 3'd4, ACT_LOW};
      5'd2, 5'd20:       s = '{CNT_FIXED, 3'd6, 3'd1, ACT_TOGGLE};
      5'd3:              s = '{CNT_FIXED, 3'd1, DLY_GAP, ACT_LOW};
      5'd6:              s = '{CNT_FIXED, 3'd2, 3'd4, ACT_TOGGLE};
      5'd7:              s = '{CNT_FIXED, 3'd2, 3'd2, ACT_TOGGLE};
      5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18:
                         s = '{CNT_EDGE, 3'd0, 3'd4, ACT_HIGH};
      5'd9, 5'd13, 5'd17: s = '{CNT_ON, 3'd0, 3'd4, ACT_LOW};
      5'd11, 5'd15, 5'd19: s = '{CNT_OFF, 3'd0, 3'd4, ACT_LOW};
      default:           s = '{CNT_FIXED, 3'd1, 3'd4, ACT_HIGH};
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/led_pulse_pattern_sequencer.sv */
// Top level of the LED pulse pattern sequencer: state update and result register.
//
// Usage:
//   Slave stream (s_*) carries one request per item: s_tuser = operation
//   (0 = 100 us tick, 1 = brightness write), s_tdata = brightness.
//   Master stream (m_*) returns one result per request: pin level, pattern
//   busy flag and step position, sampled after the request is applied.
//   The cfg_* port writes the count and gap registers; the user must use it
//   only while the block idles, as the block itself does not enforce this.
// Result: registered, shown on m_* in the cycle after the request is taken.
// Throughput: one request per cycle unless m_* stalls; the whole update is one table lookup, one
//   count compare and one wait decrement ahead of the state registers.
// Reset: rst (synchronous) clears the pin, busy flag, step, counters, pattern
//   select and remembered brightness, and loads the register defaults.
// Stall: while m_tready is low a held result blocks s_tready; the result
//   register takes the next request the cycle the old result is taken.
module led_pulse_pattern_sequencer
  import lpps_pkg::*;
#(
  parameter int SEQUENCE_LENGTH = SeqLengthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] brightness
  input  logic                 s_tuser,   // [0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] pin_out, [1] pattern_busy,
                                          // [6:2] step_position, [7] zero
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  localparam int IdxW = $clog2(SEQUENCE_LENGTH + 1);
  localparam logic [IdxW-1:0] SeqEnd = IdxW'(SEQUENCE_LENGTH);

  // Configuration registers
  logic [CountW-1:0] slow_edge, slow_on, slow_off;
  logic [CountW-1:0] fast_edge, fast_on, fast_off;
  logic [WaitW-1:0]  reset_gap;

  // Sequencer state
  logic              pin_level, busy_flag, fast_selected;
  logic [IdxW-1:0]   step_index;
  logic [CountW-1:0] action_count;
  logic [WaitW-1:0]  wait_ticks;
  logic [7:0]        previous_brightness;

  logic              pin_level_next, busy_flag_next, fast_selected_next;
  logic [IdxW-1:0]   step_index_next;
  logic [CountW-1:0] action_count_next;
  logic [WaitW-1:0]  wait_ticks_next;
  logic [7:0]        previous_brightness_next;

  logic              take;
  step_t             step;
  logic [CountW-1:0] step_cnt;
  logic [WaitW-1:0]  step_delay;
  logic [WaitW-1:0]  wait_dec;
  logic              plain;
  logic [7:0]        level;

  assign take     = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_edge <= SLOW_EDGE_RST;
      slow_on   <= SLOW_ON_RST;
      slow_off  <= SLOW_OFF_RST;
      fast_edge <= FAST_EDGE_RST;
      fast_on   <= FAST_ON_RST;
      fast_off  <= FAST_OFF_RST;
      reset_gap <= GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOW_EDGE: slow_edge <= cfg_data[CountW-1:0];
        REG_SLOW_ON:   slow_on   <= cfg_data[CountW-1:0];
        REG_SLOW_OFF:  slow_off  <= cfg_data[CountW-1:0];
        REG_FAST_EDGE: fast_edge <= cfg_data[CountW-1:0];
        REG_FAST_ON:   fast_on   <= cfg_data[CountW-1:0];
        REG_FAST_OFF:  fast_off  <= cfg_data[CountW-1:0];
        REG_GAP:       reset_gap <= cfg_data[WaitW-1:0];
        default: ;
      endcase
    end
  end

  // Look up the current step, its count and its delay
  always_comb begin
    step = step_lookup(step_index[PosW-1:0]);
    case (step.src)
      CNT_EDGE: step_cnt = fast_selected ? fast_edge : slow_edge;
      CNT_ON:   step_cnt = fast_selected ? fast_on : slow_on;
      CNT_OFF:  step_cnt = fast_selected ? fast_off : slow_off;
      default:  step_cnt = CountW'(step.count);
    endcase
    step_delay = (step.delay == DLY_GAP) ? reset_gap : WaitW'(step.delay);
    wait_dec   = (wait_ticks != '0) ? wait_ticks - WaitW'(1) : '0;
  end

  // Apply one tick or brightness write
  always_comb begin
    pin_level_next           = pin_level;
    busy_flag_next           = busy_flag;
    fast_selected_next       = fast_selected;
    step_index_next          = step_index;
    action_count_next        = action_count;
    wait_ticks_next          = wait_ticks;
    previous_brightness_next = previous_brightness;
    plain = (s_tdata == BR_LOW) || (s_tdata == BR_HIGH);
    level = (!plain && previous_brightness == s_tdata) ? BR_HIGH : s_tdata;
    if (take) begin
      if (s_tuser == OP_WRITE) begin
        if (!plain) previous_brightness_next = s_tdata;
        case (level) inside
          BR_LOW:  pin_level_next = 1'b0;
          BR_HIGH: pin_level_next = 1'b1;
          BR_SLOW, BR_FAST: begin
            fast_selected_next = (level == BR_FAST);
            step_index_next    = '0;
            pin_level_next     = 1'b0;
            wait_ticks_next    = '0;
            busy_flag_next     = 1'b1;
          end
          default: ;
        endcase
      end else if (busy_flag) begin
        wait_ticks_next = wait_dec;
        if (wait_dec == '0) begin
          if (step_index >= SeqEnd) begin
            busy_flag_next = 1'b0;
          end else begin
            if (action_count >= step_cnt) begin
              // advance to the next step
              action_count_next = '0;
              step_index_next   = step_index + IdxW'(1);
              if (step_index + IdxW'(1) >= SeqEnd) busy_flag_next = 1'b0;
            end else begin
              case (step.act)
                ACT_LOW:  pin_level_next = 1'b0;
                ACT_HIGH: pin_level_next = 1'b1;
                default:  pin_level_next = !pin_level;
              endcase
              action_count_next = action_count + CountW'(1);
            end
            wait_ticks_next = step_delay;
          end
        end
      end
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_level           <= 1'b0;
      busy_flag           <= 1'b0;
      fast_selected       <= 1'b0;
      step_index          <= '0;
      action_count        <= '0;
      wait_ticks          <= '0;
      previous_brightness <= '0;
    end else begin
      pin_level           <= pin_level_next;
      busy_flag           <= busy_flag_next;
      fast_selected       <= fast_selected_next;
      step_index          <= step_index_next;
      action_count        <= action_count_next;
      wait_ticks          <= wait_ticks_next;
      previous_brightness <= previous_brightness_next;
    end
  end

  // Register the result of each request
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {1'b0, step_index_next[PosW-1:0], busy_flag_next, pin_level_next};
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_index <= SeqEnd)
    else $error("step index ran past the pattern end");

  a_busy_in_range: assert property (@(posedge clk) disable iff (rst)
    busy_flag |-> step_index < SeqEnd)
    else $error("pattern busy at or past its end");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("accepted request produced no result");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(step_index) && $stable(busy_flag) && $stable(pin_level))
    else $error("sequencer state changed without a request");
`endif

endmodule
